[design/kpat_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed profile accumulator table: shared definitions
// Field widths, default sizes, opcodes, controller states and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kpat_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int KEY_CHARS_DEF = 8;
    localparam int TIME_BITS_DEF = 32;

    localparam int OP_W   = 2;
    localparam int TAG_W  = 64;
    localparam int CPU_W  = 4;
    localparam int TS_W   = 32;
    localparam int RIDX_W = 5;
    localparam int EIDX_W = 5;
    localparam int CNT_W  = 32;
    localparam int DUR_W  = 64;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_STAT,
        S_DELTA,
        S_ACCUM,
        S_READ,
        S_READ_DATA,
        S_LOAD
    } state_t;

    typedef struct packed {
        logic load;
        logic search;
        logic stat_rd;
        logic delta;
        logic accum;
        logic read_issue;
        logic read_cap;
        logic load_out;
    } kpat_cmd_t;

    typedef struct packed {
        logic hit;
        logic miss;
    } kpat_sts_t;

endpackage

[design/keyed_profile_accumulator_table.sv]
`timescale 1ns / 1ps
// Start and stop items search the keys one entry a cycle until a match or the end of the used entries;
// a read item fetches the addressed entry, and opcode three goes straight to the result register. One
// item is in work at a time; the next is accepted in the cycle after the result is loaded.
// Reset clears the fill count and the overflow-entry flag; statistics of unused entries read as zero.
// ----------------------------------------------------------------------------
// Keyed profile accumulator table
// Profiling table keyed by tag and cpu: start and stop items update call
// counts and durations, read items return one entry.
// ----------------------------------------------------------------------------
module keyed_profile_accumulator_table
    import kpat_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int KEY_CHARS = KEY_CHARS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0: tag, cpu, timestamp, read_index, zero padding.
    input  logic [111:0] s_axis_tdata,
    // Fields from bit 0: opcode.
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0: entry_index, was_added, overflowed, entry_valid, entry_tag,
    // entry_cpu, call_total, duration_total, zero padding.
    output logic [175:0] m_axis_tdata
);

    kpat_cmd_t         cmd;
    kpat_sts_t         sts;
    logic [EIDX_W-1:0] entry_index;
    logic              was_added;
    logic              overflowed;
    logic              entry_valid;
    logic [TAG_W-1:0]  entry_tag;
    logic [CPU_W-1:0]  entry_cpu;
    logic [CNT_W-1:0]  call_total;
    logic [DUR_W-1:0]  duration_total;

    kpat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    kpat_dp #(
        .ENTRIES   (ENTRIES),
        .KEY_CHARS (KEY_CHARS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_op          (s_axis_tuser),
        .in_tag         (s_axis_tdata[63:0]),
        .in_cpu         (s_axis_tdata[67:64]),
        .in_ts          (s_axis_tdata[99:68]),
        .in_ridx        (s_axis_tdata[104:100]),
        .entry_index    (entry_index),
        .was_added      (was_added),
        .overflowed     (overflowed),
        .entry_valid    (entry_valid),
        .entry_tag      (entry_tag),
        .entry_cpu      (entry_cpu),
        .call_total     (call_total),
        .duration_total (duration_total)
    );

    assign m_axis_tdata = {4'd0, duration_total, call_total, entry_cpu, entry_tag,
                           entry_valid, overflowed, was_added, entry_index};

endmodule

[design/kpat_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed profile accumulator table: controller
// Sequences the key search, statistics update or entry read for one item and
// owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module kpat_ctrl
    import kpat_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [OP_W-1:0] in_op,
    output logic            out_valid,
    input  logic            out_ready,
    output kpat_cmd_t       cmd,
    input  kpat_sts_t       sts
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (opcode_t'(in_op))
                        OP_START: state_next = S_SEARCH;
                        OP_STOP:  state_next = S_SEARCH;
                        OP_READ:  state_next = S_READ;
                        default:  state_next = S_LOAD;
                    endcase
                end
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (sts.hit || sts.miss)
                begin
                    state_next = S_STAT;
                end
            end
            S_STAT:
            begin
                cmd.stat_rd = 1'b1;
                state_next  = S_DELTA;
            end
            S_DELTA:
            begin
                cmd.delta  = 1'b1;
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = S_LOAD;
            end
            S_READ:
            begin
                cmd.read_issue = 1'b1;
                state_next     = S_READ_DATA;
            end
            S_READ_DATA:
            begin
                cmd.read_cap = 1'b1;
                state_next   = S_LOAD;
            end
            S_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[design/kpat_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed profile accumulator table: datapath
// Key and statistics memories, the entry search, the statistics arithmetic and
// the output payload register.
// ----------------------------------------------------------------------------
module kpat_dp
    import kpat_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int KEY_CHARS = KEY_CHARS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  kpat_cmd_t         cmd,
    output kpat_sts_t         sts,
    input  logic [OP_W-1:0]   in_op,
    input  logic [TAG_W-1:0]  in_tag,
    input  logic [CPU_W-1:0]  in_cpu,
    input  logic [TS_W-1:0]   in_ts,
    input  logic [RIDX_W-1:0] in_ridx,
    output logic [EIDX_W-1:0] entry_index,
    output logic              was_added,
    output logic              overflowed,
    output logic              entry_valid,
    output logic [TAG_W-1:0]  entry_tag,
    output logic [CPU_W-1:0]  entry_cpu,
    output logic [CNT_W-1:0]  call_total,
    output logic [DUR_W-1:0]  duration_total
);

    localparam int IW     = $clog2(ENTRIES + 1);
    localparam int KW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW     = (IW > RIDX_W) ? IW : RIDX_W;
    localparam int NCHARS = TAG_W / 8;
    localparam logic [DUR_W-1:0] TIME_MASK =
        (TIME_BITS >= DUR_W) ? {DUR_W{1'b1}} : ((64'd1 << TIME_BITS) - 64'd1);

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [CPU_W-1:0] cpu;
    } key_t;

    typedef struct packed {
        logic [TS_W-1:0]  start;
        logic [CNT_W-1:0] count;
        logic [DUR_W-1:0] dur;
    } stat_t;

    function automatic logic [TAG_W-1:0] norm_tag(input logic [TAG_W-1:0] t);
        logic [TAG_W-1:0] r;
        logic             stop;
        r    = '0;
        stop = 1'b0;
        for (int k = 0; k < NCHARS; k++)
        begin
            if (k >= KEY_CHARS || t[8*k +: 8] == 8'd0)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                r[8*k +: 8] = t[8*k +: 8];
            end
        end
        return r;
    endfunction

    key_t  key_mem [ENTRIES];
    stat_t stat_mem [ENTRIES + 1];

    opcode_t           op_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [CPU_W-1:0]  cpu_reg;
    logic [TS_W-1:0]   ts_reg;
    logic [RIDX_W-1:0] ridx_reg;

    logic [IW-1:0] used_reg;
    logic [IW-1:0] used_next;
    logic          ovf_seen_reg;
    logic          ovf_seen_next;
    logic [IW-1:0] scan_reg;
    logic          pend_reg;
    logic [IW-1:0] pend_idx_reg;
    logic [IW-1:0] idx_reg;
    logic          added_reg;
    logic          ovf_reg;
    logic          valid_reg;
    logic          live_reg;
    logic          keyhit_reg;

    key_t  key_q_reg;
    stat_t stat_q_reg;

    logic [TS_W-1:0]  new_start_reg;
    logic [CNT_W-1:0] new_count_reg;
    logic [DUR_W-1:0] base_dur_reg;
    logic [DUR_W-1:0] delta_reg;

    logic [TAG_W-1:0] tag_res_reg;
    logic [CPU_W-1:0] cpu_res_reg;
    logic [CNT_W-1:0] count_res_reg;
    logic [DUR_W-1:0] dur_res_reg;

    logic [EIDX_W-1:0] out_index_reg;
    logic              out_added_reg;
    logic              out_ovf_reg;
    logic              out_valid_reg;
    logic [TAG_W-1:0]  out_tag_reg;
    logic [CPU_W-1:0]  out_cpu_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic [DUR_W-1:0]  out_dur_reg;

    logic             scan_issue;
    logic             room;
    logic [CW-1:0]    ridx_ext;
    logic             rd_used;
    logic             rd_ovf;
    stat_t            stat_base;
    logic [DUR_W-1:0] stop_delta;
    logic [DUR_W-1:0] dur_sum;

    assign scan_issue = scan_reg < used_reg;
    assign room       = used_reg < IW'(ENTRIES);
    assign ridx_ext   = CW'(ridx_reg);
    assign rd_used    = ridx_ext < CW'(used_reg);
    assign rd_ovf     = ridx_ext == CW'(ENTRIES);
    assign stat_base  = live_reg ? stat_q_reg : '0;
    assign stop_delta = ({32'd0, ts_reg} - {32'd0, stat_base.start}) & TIME_MASK;
    assign dur_sum    = base_dur_reg + delta_reg;

    assign sts.hit  = cmd.search && pend_reg && (key_q_reg == {tag_reg, cpu_reg});
    assign sts.miss = cmd.search && !pend_reg && !scan_issue;

    always_comb
    begin
        used_next = used_reg;
        if (sts.miss && room)
        begin
            used_next = used_reg + 1'b1;
        end
        ovf_seen_next = ovf_seen_reg || (cmd.accum && ovf_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            ovf_seen_reg <= 1'b0;
            scan_reg     <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            idx_reg      <= '0;
            added_reg    <= 1'b0;
            ovf_reg      <= 1'b0;
            valid_reg    <= 1'b0;
            live_reg     <= 1'b0;
            keyhit_reg   <= 1'b0;
        end
        else
        begin
            used_reg     <= used_next;
            ovf_seen_reg <= ovf_seen_next;
            if (cmd.load)
            begin
                scan_reg   <= '0;
                pend_reg   <= 1'b0;
                added_reg  <= 1'b0;
                ovf_reg    <= 1'b0;
                valid_reg  <= 1'b0;
                live_reg   <= 1'b0;
                keyhit_reg <= 1'b0;
            end
            else if (cmd.search)
            begin
                scan_reg     <= scan_issue ? scan_reg + 1'b1 : scan_reg;
                pend_reg     <= scan_issue;
                pend_idx_reg <= scan_reg;
                if (sts.hit)
                begin
                    idx_reg   <= pend_idx_reg;
                    valid_reg <= 1'b1;
                    live_reg  <= 1'b1;
                end
                else if (sts.miss && room)
                begin
                    idx_reg   <= used_reg;
                    added_reg <= 1'b1;
                    valid_reg <= 1'b1;
                    live_reg  <= 1'b0;
                end
                else if (sts.miss)
                begin
                    idx_reg   <= IW'(ENTRIES);
                    ovf_reg   <= 1'b1;
                    valid_reg <= 1'b1;
                    live_reg  <= ovf_seen_reg;
                end
            end
            else if (cmd.read_issue)
            begin
                valid_reg  <= rd_used || rd_ovf;
                live_reg   <= rd_used || (rd_ovf && ovf_seen_reg);
                keyhit_reg <= rd_used;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sts.miss && room)
        begin
            key_mem[used_reg[KW-1:0]] <= {tag_reg, cpu_reg};
        end
        if (cmd.search && scan_issue)
        begin
            key_q_reg <= key_mem[scan_reg[KW-1:0]];
        end
        else if (cmd.read_issue && rd_used)
        begin
            key_q_reg <= key_mem[ridx_ext[KW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accum)
        begin
            stat_mem[idx_reg] <= {new_start_reg, new_count_reg, dur_sum};
        end
        if (cmd.stat_rd)
        begin
            stat_q_reg <= stat_mem[idx_reg];
        end
        else if (cmd.read_issue && (rd_used || rd_ovf))
        begin
            stat_q_reg <= stat_mem[ridx_ext[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode_t'(in_op);
            tag_reg  <= norm_tag(in_tag);
            cpu_reg  <= in_cpu;
            ts_reg   <= in_ts;
            ridx_reg <= in_ridx;
        end
        if (sts.hit || (sts.miss && room))
        begin
            tag_res_reg <= tag_reg;
            cpu_res_reg <= cpu_reg;
        end
        else if (sts.miss)
        begin
            tag_res_reg <= '0;
            cpu_res_reg <= '0;
        end
        else if (cmd.read_cap)
        begin
            tag_res_reg   <= keyhit_reg ? key_q_reg.tag : '0;
            cpu_res_reg   <= keyhit_reg ? key_q_reg.cpu : '0;
            count_res_reg <= stat_base.count;
            dur_res_reg   <= stat_base.dur;
        end
        if (cmd.delta)
        begin
            new_start_reg <= (op_reg == OP_START) ? ts_reg : stat_base.start;
            new_count_reg <= stat_base.count + CNT_W'(op_reg == OP_START);
            base_dur_reg  <= stat_base.dur;
            delta_reg     <= (op_reg == OP_START) ? '0 : stop_delta;
        end
        if (cmd.accum)
        begin
            count_res_reg <= new_count_reg;
            dur_res_reg   <= dur_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (op_reg == OP_NONE)
            begin
                out_index_reg <= '0;
                out_added_reg <= 1'b0;
                out_ovf_reg   <= 1'b0;
                out_valid_reg <= 1'b0;
                out_tag_reg   <= '0;
                out_cpu_reg   <= '0;
                out_count_reg <= '0;
                out_dur_reg   <= '0;
            end
            else
            begin
                out_index_reg <= (op_reg == OP_READ) ? EIDX_W'(ridx_reg) : EIDX_W'(idx_reg);
                out_added_reg <= added_reg;
                out_ovf_reg   <= ovf_reg;
                out_valid_reg <= valid_reg;
                out_tag_reg   <= valid_reg ? tag_res_reg : '0;
                out_cpu_reg   <= valid_reg ? cpu_res_reg : '0;
                out_count_reg <= valid_reg ? count_res_reg : '0;
                out_dur_reg   <= valid_reg ? dur_res_reg : '0;
            end
        end
    end

    assign entry_index    = out_index_reg;
    assign was_added      = out_added_reg;
    assign overflowed     = out_ovf_reg;
    assign entry_valid    = out_valid_reg;
    assign entry_tag      = out_tag_reg;
    assign entry_cpu      = out_cpu_reg;
    assign call_total     = out_count_reg;
    assign duration_total = out_dur_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= IW'(ENTRIES))
        else $error("Fill count exceeds the table size.");

    a_hit_miss: assert property (@(posedge clk) disable iff (!rst_n)
        !(sts.hit && sts.miss))
        else $error("Search reports a hit and a miss together.");

    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        (sts.miss && room) |=> (used_reg == $past(used_reg) + 1'b1))
        else $error("Appending an entry did not advance the fill count.");

    a_ovf_index: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (idx_reg == IW'(ENTRIES) && !added_reg))
        else $error("Overflow item does not point at the shared entry.");

endmodule
